### hdl/mrt_pkg.sv
// Shared types and constants for the 4x4 row transform.
// No dependencies; imported by mrt_column, matrix4x4_row_transform and tb.
package mrt_pkg;

    localparam int DIM    = 4;
    localparam int ELEM_W = 32;

    // Request codes carried on the req_type field.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MULT = 1'b1;

    typedef logic signed [ELEM_W-1:0] t_elem;

    // Per-stage capture enables for the arithmetic stages of one column.
    typedef struct packed {
        logic s2;   // products
        logic s3;   // pair sums
        logic s4;   // full sum
        logic s5;   // shift and saturate
    } t_adv;

endpackage

### hdl/matrix4x4_row_transform.sv
// Top level of the 4x4 row transform: handshake, B storage, pipeline control.
// Depends on mrt_pkg and mrt_column.
//
// Streams rows of A through A x B, one transaction per clock while the output
// side does not stall. B is held in sixteen registers, cleared to zero at
// reset, and written one row per load transaction (req_type 0); a load
// produces no result. A multiply transaction (req_type 1) passes an input
// register, a product register behind 16 parallel 32x32 multipliers and two
// adder-tree registers; shift/saturate logic then feeds the output register,
// which presents that row of the product. Loads write B as they leave the
// input register, the same place multiplies read it, so every multiply sees
// exactly the loads that preceded it. Each stage keeps its own valid bit, so
// bubbles collapse and a stall at the output backs up without losing or
// repeating a transaction. Elements are signed fixed point with FRAC_BITS
// fraction bits; each sum is shifted right arithmetically and saturated to
// 32 bits.
module matrix4x4_row_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input channel
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_req_type,
    input  logic [1:0]     i_row_index,
    input  mrt_pkg::t_elem i_elem_0,
    input  mrt_pkg::t_elem i_elem_1,
    input  mrt_pkg::t_elem i_elem_2,
    input  mrt_pkg::t_elem i_elem_3,
    // output channel
    output logic           o_valid,
    input  logic           i_ready,
    output mrt_pkg::t_elem o_out_0,
    output mrt_pkg::t_elem o_out_1,
    output mrt_pkg::t_elem o_out_2,
    output mrt_pkg::t_elem o_out_3
);
    import mrt_pkg::*;

    // Stage 1: input register.
    logic       r_v1;
    logic       r_type;
    logic [1:0] r_row;
    t_elem      r_a [DIM];

    // Valid bits of the arithmetic stages; r_v5 drives o_valid.
    logic r_v2, r_v3, r_v4, r_v5;

    // Right-hand matrix B, row-major.
    t_elem r_b [DIM*DIM];

    logic  w_go1, w_go2, w_go3, w_go4, w_go5;
    t_adv  w_adv;
    logic  w_b_wr;
    t_elem w_col_b [DIM][DIM];
    t_elem w_out   [DIM];

    // A stage captures when it is empty or its content moves on.
    assign w_go5 = !r_v5 || i_ready;
    assign w_go4 = !r_v4 || w_go5;
    assign w_go3 = !r_v3 || w_go4;
    assign w_go2 = !r_v2 || w_go3;
    assign w_go1 = !r_v1 || w_go2;

    assign o_ready = w_go1;
    assign o_valid = r_v5;

    assign w_adv = '{s2: w_go2, s3: w_go3, s4: w_go4, s5: w_go5};

    // Commit a load as it leaves the input register.
    assign w_b_wr = r_v1 && (r_type == REQ_LOAD) && w_go2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_go1) begin
                r_v1 <= i_valid;
            end
            // Drop loads here: they make no result.
            if (w_go2) begin
                r_v2 <= r_v1 && (r_type == REQ_MULT);
            end
            if (w_go3) begin
                r_v3 <= r_v2;
            end
            if (w_go4) begin
                r_v4 <= r_v3;
            end
            if (w_go5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // Hold the accepted transaction's payload.
    always_ff @(posedge i_clk) begin
        if (w_go1) begin
            r_type <= i_req_type;
            r_row  <= i_row_index;
            r_a[0] <= i_elem_0;
            r_a[1] <= i_elem_1;
            r_a[2] <= i_elem_2;
            r_a[3] <= i_elem_3;
        end
    end

    // B storage: cleared at reset, one row written per load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIM*DIM; i++) begin
                r_b[i] <= '0;
            end
        end else if (w_b_wr) begin
            for (int c = 0; c < DIM; c++) begin
                r_b[{r_row, 2'(c)}] <= r_a[c];
            end
        end
    end

    // Column c of B feeds output column c.
    always_comb begin
        for (int c = 0; c < DIM; c++) begin
            for (int k = 0; k < DIM; k++) begin
                w_col_b[c][k] = r_b[k*DIM + c];
            end
        end
    end

    for (genvar c = 0; c < DIM; c++) begin : g_col
        mrt_column #(
            .FRAC_BITS (FRAC_BITS)
        ) u_col (
            .i_clk (i_clk),
            .i_adv (w_adv),
            .i_a   (r_a),
            .i_b   (w_col_b[c]),
            .o_out (w_out[c])
        );
    end

    assign o_out_0 = w_out[0];
    assign o_out_1 = w_out[1];
    assign o_out_2 = w_out[2];
    assign o_out_3 = w_out[3];

endmodule

### hdl/mrt_column.sv
// One output column of the row transform: four products, adder tree, shift, saturate.
// Depends on mrt_pkg.
module mrt_column #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  mrt_pkg::t_adv i_adv,
    input  mrt_pkg::t_elem i_a [mrt_pkg::DIM],
    input  mrt_pkg::t_elem i_b [mrt_pkg::DIM],
    output mrt_pkg::t_elem o_out
);
    import mrt_pkg::*;

    localparam int PROD_W = 2 * ELEM_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [PROD_W-1:0] r_prod [DIM];
    logic signed [PAIR_W-1:0] r_pair [DIM/2];
    logic signed [SUM_W-1:0]  r_sum;
    t_elem                    r_out;

    logic signed [SUM_W-1:0]  w_shift;
    logic [SUM_W-ELEM_W:0]    w_hi;
    t_elem                    n_out;

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            for (int k = 0; k < DIM; k++) begin
                r_prod[k] <= PROD_W'($signed(i_a[k]) * $signed(i_b[k]));
            end
        end
        if (i_adv.s3) begin
            for (int p = 0; p < DIM/2; p++) begin
                r_pair[p] <= {r_prod[2*p][PROD_W-1], r_prod[2*p]}
                           + {r_prod[2*p+1][PROD_W-1], r_prod[2*p+1]};
            end
        end
        if (i_adv.s4) begin
            r_sum <= {r_pair[0][PAIR_W-1], r_pair[0]} + {r_pair[1][PAIR_W-1], r_pair[1]};
        end
        if (i_adv.s5) begin
            r_out <= n_out;
        end
    end

    // Truncate toward minus infinity, then clamp to the 32-bit signed range.
    always_comb begin
        w_shift = r_sum >>> FRAC_BITS;
        w_hi    = w_shift[SUM_W-1:ELEM_W-1];
        if ((&w_hi) || !(|w_hi)) begin
            n_out = w_shift[ELEM_W-1:0];
        end else if (w_shift[SUM_W-1]) begin
            n_out = {1'b1, {(ELEM_W-1){1'b0}}};
        end else begin
            n_out = {1'b0, {(ELEM_W-1){1'b1}}};
        end
    end

    assign o_out = r_out;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix4x4_row_transform (row of A times stored B).
// Depends on mrt_pkg and the RTL; a local product model predicts every result.
module tb;

    import mrt_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int QUIET_MAX  = 4000;   // cycles with no transaction before giving up
    localparam int HOLD_LEN   = 300;    // long receiver hold-off
    localparam int TAIL_WAIT  = 32;     // settle time after the last result

    localparam logic [31:0] ONE_Q   = 32'h0001_0000;
    localparam logic [31:0] MAX_Q   = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_Q   = 32'h8000_0000;
    localparam logic [31:0] NEG_LSB = 32'hFFFF_FFFF;

    localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
    localparam logic signed [79:0] SAT_LO = -80'sd2147483648;

    // One row of four Q16.16 elements, element c in slice [c].
    typedef logic [3:0][31:0] t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_req_type;
    logic [1:0] i_row_index;
    t_elem      i_elem_0, i_elem_1, i_elem_2, i_elem_3;
    logic       o_valid;
    logic       i_ready;
    t_elem      o_out_0, o_out_1, o_out_2, o_out_3;

    logic [31:0] matrix_b [16];         // predicted B, row-major
    t_row        pending_products [$];  // expected product rows, oldest first
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          hold_cycles;           // receiver hold-off still to run
    logic        idle_on;               // random idling on both sides

    matrix4x4_row_transform #(
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_row_index (i_row_index),
        .i_elem_0    (i_elem_0),
        .i_elem_1    (i_elem_1),
        .i_elem_2    (i_elem_2),
        .i_elem_3    (i_elem_3),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_0     (o_out_0),
        .o_out_1     (o_out_1),
        .o_out_2     (o_out_2),
        .o_out_3     (o_out_3)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Product model: exact wide sum of four 64-bit products, arithmetic
    // shift (rounds toward minus infinity), then clamp to 32 bits.
    // ------------------------------------------------------------------
    function automatic t_row product_row(input t_row a);
        logic signed [79:0] acc;
        logic signed [79:0] shifted;
        longint             prod;
        t_row               r;
        for (int c = 0; c < 4; c++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
                prod = longint'($signed(a[k])) * longint'($signed(matrix_b[k*4 + c]));
                acc  = acc + prod;
            end
            shifted = acc >>> FRAC_BITS;
            if (shifted > SAT_HI)
                r[c] = MAX_Q;
            else if (shifted < SAT_LO)
                r[c] = MIN_Q;
            else
                r[c] = shifted[31:0];
        end
        return r;
    endfunction

    function automatic t_row make_row(input logic [31:0] e0, e1, e2, e3);
        t_row r;
        r[0] = e0;
        r[1] = e1;
        r[2] = e2;
        r[3] = e3;
        return r;
    endfunction

    // Mix of corner values, full-range words and small in-range values.
    function automatic logic [31:0] rand_elem();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return MIN_Q;
                    1: return MAX_Q;
                    2: return NEG_LSB;
                    3: return ONE_Q;
                    default: return '0;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return $urandom_range(32'h000F_FFFF) - 32'd524288;
        endcase
    endfunction

    function automatic t_row rand_row();
        return make_row(rand_elem(), rand_elem(), rand_elem(), rand_elem());
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional idle gap, then offer one transaction and hold it
    // until accepted. Update the model at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [1:0] row, input t_row elems);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(99) < 29)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= kind;
        i_row_index <= row;
        i_elem_0    <= elems[0];
        i_elem_1    <= elems[1];
        i_elem_2    <= elems[2];
        i_elem_3    <= elems[3];
        do @(posedge i_clk); while (!o_ready);
        if (kind == REQ_LOAD) begin
            for (int c = 0; c < 4; c++)
                matrix_b[int'(row)*4 + c] = elems[c];
        end else begin
            pending_products.push_back(product_row(elems));
        end
    endtask

    // Drop valid and hold the sender until every expected row is back.
    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_products.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a counted hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_ready     <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= !(idle_on && $urandom_range(99) < 29);
        end
    end

    // Check each output transaction against the oldest expected row.
    always @(posedge i_clk) begin
        t_row got;
        t_row want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_out_3, o_out_2, o_out_1, o_out_0};
            if (pending_products.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h %h %h", got[0], got[1], got[2], got[3]);
            end else begin
                want = pending_products.pop_front();
                for (int c = 0; c < 4; c++) begin
                    if (got[c] !== want[c]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("out_%0d mismatch: expected %h, got %h",
                                     c, want[c], got[c]);
                    end
                end
            end
        end
    end

    // Watchdog: count edges with no transaction on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // B is all zero after reset, so every product row is zero.
    task automatic test_unloaded_rows();
        send_item(REQ_MULT, 2'd3, make_row(ONE_Q, ONE_Q << 1, NEG_LSB, MIN_Q));
    endtask

    // Load identity into B; extremes pass through unchanged, row_index ignored.
    task automatic test_identity_passthrough();
        t_row r;
        for (int k = 0; k < 4; k++) begin
            r    = '0;
            r[k] = ONE_Q;
            send_item(REQ_LOAD, 2'(k), r);
        end
        send_item(REQ_MULT, 2'd2, make_row(MAX_Q, MIN_Q, NEG_LSB, 32'd1));
        send_item(REQ_MULT, 2'd1, make_row('0, '0, ONE_Q, '0));
    endtask

    // Drive the wide sum past both clamps, and right onto the boundaries.
    task automatic test_saturation();
        send_item(REQ_LOAD, 2'd0, make_row(MIN_Q, MIN_Q, MIN_Q, MIN_Q));
        send_item(REQ_LOAD, 2'd1, make_row(MIN_Q, MIN_Q, MIN_Q, MIN_Q));
        send_item(REQ_MULT, 2'd0, make_row(MIN_Q, MIN_Q, '0, '0));
        send_item(REQ_MULT, 2'd3, make_row(MAX_Q, MAX_Q, '0, '0));
        send_item(REQ_MULT, 2'd1, make_row(32'hFFFF_0000, '0, '0, '0));  // one past max
        send_item(REQ_MULT, 2'd2, make_row(ONE_Q, '0, '0, '0));          // exactly min
        send_item(REQ_LOAD, 2'd2, make_row(MAX_Q, MAX_Q, MAX_Q, MAX_Q));
        send_item(REQ_MULT, 2'd0, make_row('0, '0, MAX_Q, '0));
        // Large products cancel inside the wide sum.
        send_item(REQ_MULT, 2'd1, make_row(MIN_Q, '0, MIN_Q, '0));
    endtask

    // Shift rounds toward minus infinity: -1 LSB stays -1, +1 LSB drops to 0.
    task automatic test_truncation();
        send_item(REQ_LOAD, 2'd3, make_row(32'd1, 32'd1, 32'd1, 32'd1));
        send_item(REQ_MULT, 2'd0, make_row('0, '0, '0, NEG_LSB));
        send_item(REQ_MULT, 2'd0, make_row('0, '0, '0, 32'd1));
        send_item(REQ_MULT, 2'd3, make_row(NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB));
    endtask

    // Random stream: mostly multiplies, with occasional row or whole-matrix
    // reloads. A stretch in the middle runs with no idling on either side.
    task automatic test_random_stream(input int n_items);
        int sent;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            idle_on <= !(sent >= n_items/3 && sent < n_items/3 + 300);
            pick = $urandom_range(99);
            if (pick < 3) begin
                for (int k = 0; k < 4; k++)
                    send_item(REQ_LOAD, 2'(k), rand_row());
                sent += 4;
            end else if (pick < 9) begin
                send_item(REQ_LOAD, 2'($urandom_range(3)), rand_row());
                sent++;
            end else begin
                send_item(REQ_MULT, 2'($urandom_range(3)), rand_row());
                sent++;
            end
        end
    endtask

    // Hold the receiver off while the sender keeps offering, so the pipeline
    // fills and stalls its input; then pause the sender until all is back, and send 20 more with idling on.
    task automatic test_backpressure();
        idle_on     <= 1'b0;
        hold_cycles <= HOLD_LEN;
        for (int i = 0; i < 40; i++)
            send_item(REQ_MULT, 2'($urandom_range(3)), rand_row());
        wait_drain();
        idle_on <= 1'b1;
        for (int i = 0; i < 20; i++)
            send_item(REQ_MULT, 2'($urandom_range(3)), rand_row());
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_req_type  <= REQ_LOAD;
        i_row_index <= '0;
        i_elem_0    <= '0;
        i_elem_1    <= '0;
        i_elem_2    <= '0;
        i_elem_3    <= '0;
        i_ready     <= 1'b0;
        hold_cycles <= 0;
        idle_on     <= 1'b1;
        for (int k = 0; k < 16; k++)
            matrix_b[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unloaded_rows();
        test_identity_passthrough();
        test_saturation();
        test_truncation();
        test_random_stream(1120);
        test_backpressure();

        wait_drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_products.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
